// ----- hw/rtl/eii_pkg.sv -----
// shared constants, types and state codes for the eased interval interpolator
// no dependencies; imported by every module of the block
package eii_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int STEP_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int MODE_W    = 2;

    localparam int MUL_W     = FRAC_BITS + 1;
    localparam int OPA_W     = VAL_W + 1;
    localparam int ACC_W     = OPA_W + 2;
    localparam int SHP_W     = FRAC_BITS + 3;
    localparam int MUL_CNT_W = $clog2(MUL_W + 1);
    localparam int DIV_CNT_W = $clog2(FRAC_BITS + 1);

    typedef logic [VAL_W-1:0]         t_val;
    typedef logic [MUL_W-1:0]         t_frac;
    typedef logic [FRAC_BITS-1:0]     t_quot;
    typedef logic signed [OPA_W-1:0]  t_opa;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;
    typedef logic [MODE_W-1:0]        t_mode;

    localparam t_frac ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam t_cfg_idx CFG_DURATION = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_START    = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_STOP     = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_MODE     = t_cfg_idx'(3);

    localparam t_mode MODE_LINEAR   = 2'd0;
    localparam t_mode MODE_EASE_IN  = 2'd1;
    localparam t_mode MODE_EASE_OUT = 2'd2;
    localparam t_mode MODE_IN_OUT   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FRAC,
        S_DIV_WAIT,
        S_SQ_GO,
        S_SQ_WAIT,
        S_CUBE_GO,
        S_CUBE_WAIT,
        S_SHAPE,
        S_SCALE_GO,
        S_SCALE_WAIT,
        S_EMIT
    } t_state;

endpackage

// ----- hw/rtl/eased_interval_interpolator_core.sv -----
// eased interval interpolator top level over eii_pkg, eii_serial_div and eii_serial_mul
// each request runs a serial divide, three passes through the shared multiplier and six
// steps in FRAC, SQ_GO, CUBE_GO, SHAPE, SCALE_GO and EMIT; the divide is skipped when t
// reaches 1; one request at a time, so a new one is taken only back in idle after the
// result is registered, later while the result waits; finished requests are dropped
// synchronous reset clears configuration, elapsed time and the finished flag
module eased_interval_interpolator_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [eii_pkg::STEP_W-1:0] i_time_step,
    output logic                      o_valid,
    input  logic                      i_ready,
    output eii_pkg::t_val             o_current_value,
    output logic                      o_done_res,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  eii_pkg::t_cfg_idx         i_cfg_index,
    input  eii_pkg::t_val             i_cfg_data
);
    import eii_pkg::*;

    t_state r_state, n_state;
    t_val   r_duration, r_start, r_stop;
    t_mode  r_mode;
    t_val   r_elapsed, n_elapsed;
    logic   r_finished, n_finished;
    t_frac  r_t, n_t;
    t_frac  r_t2, n_t2;
    t_frac  r_t3, n_t3;
    t_frac  r_s, n_s;
    t_val   r_cur, n_cur;
    logic   r_out_valid, n_out_valid;
    logic   r_done_out, n_done_out;

    logic  div_start, div_done;
    t_quot div_quot;
    logic  mul_start, mul_done;
    t_opa  mul_a;
    t_frac mul_b;
    t_acc  mul_hi;
    t_frac mul_lo;

    logic           accept;
    logic           out_free;
    logic [VAL_W:0] step_sum;
    t_frac          mul_frac;
    t_val           scaled;
    logic [SHP_W-1:0] x_t, x_t2, x_t3, three_t2, three_t, shaped;

    eii_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_elapsed),
        .i_divisor  (r_duration),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    eii_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_hi    (mul_hi),
        .o_lo    (mul_lo)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;

    always_comb begin
        step_sum = {1'b0, r_elapsed} + {{(VAL_W + 1 - STEP_W){1'b0}}, i_time_step};
        mul_frac = {mul_hi[FRAC_BITS-1:0], mul_lo[MUL_W-1]};
        scaled   = r_start + {mul_hi[VAL_W-2:0], mul_lo[MUL_W-1]}
                 + {{(VAL_W-1){1'b0}}, mul_lo[MUL_W-2]};

        x_t      = {2'b00, r_t};
        x_t2     = {2'b00, r_t2};
        x_t3     = {2'b00, r_t3};
        three_t2 = (x_t2 << 1) + x_t2;
        three_t  = (x_t << 1) + x_t;
        case (r_mode)
            MODE_EASE_IN:  shaped = (three_t2 - x_t3) >> 1;
            MODE_EASE_OUT: shaped = (three_t - x_t3) >> 1;
            MODE_IN_OUT:   shaped = three_t2 - (x_t3 << 1);
            default:       shaped = x_t;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_elapsed   = r_elapsed;
        n_finished  = r_finished;
        n_t         = r_t;
        n_t2        = r_t2;
        n_t3        = r_t3;
        n_s         = r_s;
        n_cur       = r_cur;
        n_out_valid = r_out_valid && !i_ready;
        n_done_out  = r_done_out;
        div_start   = 1'b0;
        mul_start   = 1'b0;
        mul_a       = {{(OPA_W-MUL_W){1'b0}}, r_t};
        mul_b       = r_t;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !r_finished) begin
                    n_elapsed = step_sum[VAL_W] ? {VAL_W{1'b1}} : step_sum[VAL_W-1:0];
                    n_state   = S_FRAC;
                end
            end
            S_FRAC: begin
                if (r_elapsed >= r_duration) begin
                    n_t     = ONE;
                    n_state = S_SQ_GO;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_t     = {1'b0, div_quot};
                    n_state = S_SQ_GO;
                end
            end
            S_SQ_GO: begin
                mul_start = 1'b1;
                n_state   = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (mul_done) begin
                    n_t2    = mul_frac;
                    n_state = S_CUBE_GO;
                end
            end
            S_CUBE_GO: begin
                mul_start = 1'b1;
                mul_a     = {{(OPA_W-MUL_W){1'b0}}, r_t2};
                n_state   = S_CUBE_WAIT;
            end
            S_CUBE_WAIT: begin
                if (mul_done) begin
                    n_t3    = mul_frac;
                    n_state = S_SHAPE;
                end
            end
            S_SHAPE: begin
                n_s     = (shaped > {2'b00, ONE}) ? ONE : shaped[MUL_W-1:0];
                n_state = S_SCALE_GO;
            end
            S_SCALE_GO: begin
                mul_start = 1'b1;
                mul_a     = {r_stop[VAL_W-1], r_stop} - {r_start[VAL_W-1], r_start};
                mul_b     = r_s;
                n_state   = S_SCALE_WAIT;
            end
            S_SCALE_WAIT: begin
                if (mul_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_cur       = scaled;
                    n_out_valid = 1'b1;
                    n_done_out  = (r_t == ONE);
                    n_finished  = (r_t == ONE);
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elapsed   <= '0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_elapsed   <= n_elapsed;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t        <= n_t;
        r_t2       <= n_t2;
        r_t3       <= n_t3;
        r_s        <= n_s;
        r_cur      <= n_cur;
        r_done_out <= n_done_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= '0;
            r_start    <= '0;
            r_stop     <= '0;
            r_mode     <= MODE_LINEAR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DURATION: r_duration <= i_cfg_data;
                CFG_START:    r_start    <= i_cfg_data;
                CFG_STOP:     r_stop     <= i_cfg_data;
                CFG_MODE:     r_mode     <= i_cfg_data[MODE_W-1:0];
                default:      ;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_current_value = r_cur;
    assign o_done_res      = r_done_out;

    a_finished_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_finished) |=> (r_state == S_IDLE) && $stable(r_elapsed))
        else $error("request after finish started work");

    a_emit_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> o_valid && (r_finished == o_done_res))
        else $error("finished flag and done result disagree");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> r_finished)
        else $error("done result without finished state");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHAPE) |-> (r_t <= ONE) && (r_t2 <= r_t) && (r_t3 <= r_t2))
        else $error("fraction powers out of range");

endmodule

// ----- hw/rtl/eii_serial_div.sv -----
// bit-serial restoring divider: fraction bits of dividend/divisor, one per cycle
// requires dividend below divisor; depends on eii_pkg
module eii_serial_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  eii_pkg::t_val  i_dividend,
    input  eii_pkg::t_val  i_divisor,
    output logic           o_done,
    output eii_pkg::t_quot o_quot
);
    import eii_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    t_val                 r_rem;
    t_val                 r_dvs;
    t_quot                r_q;

    logic [VAL_W:0] rem2;
    logic [VAL_W:0] sub;
    logic           ge;
    t_val           n_rem;

    always_comb begin
        rem2  = {r_rem, 1'b0};
        sub   = rem2 - {1'b0, r_dvs};
        ge    = rem2 >= {1'b0, r_dvs};
        n_rem = ge ? sub[VAL_W-1:0] : rem2[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dvs <= i_divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[FRAC_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- hw/rtl/eii_serial_mul.sv -----
// shift-add multiplier: signed multiplicand times unsigned fraction, one bit per cycle
// product is {o_hi, o_lo}; depends on eii_pkg
module eii_serial_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  eii_pkg::t_opa  i_a,
    input  eii_pkg::t_frac i_b,
    output logic           o_done,
    output eii_pkg::t_acc  o_hi,
    output eii_pkg::t_frac o_lo
);
    import eii_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    t_opa                 r_a;
    t_frac                r_b;
    t_acc                 r_hi;
    t_frac                r_lo;

    t_acc  sum;
    t_acc  n_hi;
    t_frac n_lo;

    always_comb begin
        sum  = r_hi + (r_b[0] ? {{(ACC_W-OPA_W){r_a[OPA_W-1]}}, r_a} : t_acc'(0));
        n_hi = {sum[ACC_W-1], sum[ACC_W-1:1]};
        n_lo = {sum[0], r_lo[MUL_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(MUL_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
            r_b  <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_hi   = r_hi;
    assign o_lo   = r_lo;

endmodule

// ----- tb/sv/eii_interval_checker.sv -----
`timescale 1ns / 1ps
// result checker for the eased interval interpolator: tracks register writes and ticks,
// predicts each result from its own interval state, compares it field by field
// depends on eii_pkg; instantiated by tb_eased_interval_interpolator_core
module eii_interval_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_tick_valid,
    input  logic                       i_tick_ready,
    input  logic [eii_pkg::STEP_W-1:0] i_time_step,
    input  logic                       i_res_valid,
    input  logic                       i_res_ready,
    input  eii_pkg::t_val              i_current_value,
    input  logic                       i_done_res,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  eii_pkg::t_cfg_idx          i_cfg_index,
    input  eii_pkg::t_val              i_cfg_data,
    output int unsigned                o_fail_count,
    output int unsigned                o_pending
);
    import eii_pkg::*;

    typedef struct packed {
        t_val value;
        logic done;
    } t_sample;

    t_val                    span_r;
    logic signed [VAL_W-1:0] from_r;
    logic signed [VAL_W-1:0] to_r;
    t_mode                   curve_r;
    t_val                    elapsed_r;
    logic                    finished_r;
    t_sample                 predicted_samples[$];
    int unsigned             fail_cnt;

    function automatic longint shape_fraction(input t_mode curve, input longint t);
        longint one;
        longint t2;
        longint t3;
        longint s;
        one = longint'(1) << FRAC_BITS;
        t2 = (t * t) >>> FRAC_BITS;
        t3 = (t2 * t) >>> FRAC_BITS;
        case (curve)
            MODE_EASE_IN:  s = (3 * t2 - t3) / 2;
            MODE_EASE_OUT: s = (3 * t - t3) / 2;
            MODE_IN_OUT:   s = 3 * t2 - 2 * t3;
            default:       s = t;
        endcase
        if (s < 0) s = 0;
        if (s > one) s = one;
        return s;
    endfunction

    task automatic advance_interval(input logic [STEP_W-1:0] step);
        logic [63:0] sum;
        logic [63:0] frac;
        longint      one;
        longint      prod;
        longint      cur;
        t_sample     smp;
        one = longint'(1) << FRAC_BITS;
        sum = 64'(elapsed_r) + 64'(step);
        elapsed_r = (sum > 64'hFFFF_FFFF) ? '1 : sum[VAL_W-1:0];
        if (span_r == '0) begin
            frac = 64'(one);
        end else begin
            frac = (64'(elapsed_r) << FRAC_BITS) / 64'(span_r);
            if (frac > 64'(one)) frac = 64'(one);
        end
        prod = shape_fraction(curve_r, longint'(frac)) * (longint'(to_r) - longint'(from_r));
        cur = longint'(from_r) + ((prod + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);
        if (frac == 64'(one)) finished_r = 1'b1;
        smp.value = cur[VAL_W-1:0];
        smp.done = finished_r;
        predicted_samples.push_back(smp);
    endtask

    always @(posedge i_clk) begin : watch
        t_sample want;
        if (!i_rst_n) begin
            span_r = '0;
            from_r = '0;
            to_r = '0;
            curve_r = MODE_LINEAR;
            elapsed_r = '0;
            finished_r = 1'b0;
            predicted_samples.delete();
            fail_cnt = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DURATION: span_r = i_cfg_data;
                    CFG_START:    from_r = i_cfg_data;
                    CFG_STOP:     to_r = i_cfg_data;
                    CFG_MODE:     curve_r = i_cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (predicted_samples.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual %h done_res %b",
                             $time, i_current_value, i_done_res);
                    fail_cnt++;
                end else begin
                    want = predicted_samples.pop_front();
                    if (i_current_value !== want.value) begin
                        $display("%0t current_value mismatch: expected %h, actual %h",
                                 $time, want.value, i_current_value);
                        fail_cnt++;
                    end
                    if (i_done_res !== want.done) begin
                        $display("%0t done_res mismatch: expected %b, actual %b",
                                 $time, want.done, i_done_res);
                        fail_cnt++;
                    end
                end
            end
            if (i_tick_valid && i_tick_ready && !finished_r) advance_interval(i_time_step);
        end
        o_fail_count <= fail_cnt;
        o_pending <= predicted_samples.size();
    end

endmodule

// ----- tb/sv/tb_eased_interval_interpolator_core.sv -----
`timescale 1ns / 1ps
// top of the eased interval interpolator testbench: clock, reset, register and tick stimulus
// with random idling, result backpressure and the final verdict
// depends on eii_pkg, eased_interval_interpolator_core, eii_interval_checker
module tb_eased_interval_interpolator_core;
    import eii_pkg::*;

    localparam int   TARGET_TICKS = 1700;
    localparam int   CALM_TICKS   = 1550;
    localparam int   HOLD_AT      = 300;
    localparam int   LONG_HOLD    = 400;
    localparam int   DRAIN_CYCLES = 120;
    localparam int   CYCLE_LIMIT  = 2_000_000;
    localparam t_val LEVEL_MIN    = 32'h8000_0000;
    localparam t_val LEVEL_MAX    = 32'h7FFF_FFFF;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [STEP_W-1:0] i_time_step = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    t_val              o_current_value;
    logic              o_done_res;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    t_cfg_idx          i_cfg_index = '0;
    t_val              i_cfg_data = '0;

    int unsigned fail_count;
    int unsigned pending;
    logic        idle_on = 1'b1;
    logic        hold_req = 1'b0;
    t_val        time_spent = '0;
    int unsigned ticks_sent = 0;
    int unsigned cycle_cnt = 0;
    int unsigned stall_left = 0;
    logic        hold_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    eased_interval_interpolator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_time_step     (i_time_step),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_current_value (o_current_value),
        .o_done_res      (o_done_res),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    eii_interval_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tick_valid    (i_valid),
        .i_tick_ready    (o_ready),
        .i_time_step     (i_time_step),
        .i_res_valid     (o_valid),
        .i_res_ready     (i_ready),
        .i_current_value (o_current_value),
        .i_done_res      (o_done_res),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: short random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left = 0;
            hold_done = 1'b0;
        end else begin
            if (stall_left > 0) begin
                stall_left--;
            end else if (hold_req && !hold_done) begin
                stall_left = LONG_HOLD;
                hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            i_ready <= (stall_left == 0);
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input t_val data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic load_interval(input t_val dur, input t_val from, input t_val to,
                                 input t_mode curve);
        write_reg(CFG_DURATION, dur);
        write_reg(CFG_START, from);
        write_reg(CFG_STOP, to);
        write_reg(CFG_MODE, t_val'(curve));
        if ($urandom_range(0, 3) == 0) begin
            write_reg(t_cfg_idx'(CFG_MODE + 1 + $urandom_range(0, 3)), $urandom());
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(input logic [STEP_W-1:0] step);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_time_step <= step;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        time_spent = time_spent + t_val'(step);
        ticks_sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 15))
            0:       return '1;
            1:       return '0;
            2, 3:    return STEP_W'($urandom());
            default: return STEP_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic t_val random_level();
        case ($urandom_range(0, 7))
            0:       return LEVEL_MIN;
            1:       return LEVEL_MAX;
            2:       return t_val'($urandom_range(0, 511)) << FRAC_BITS;
            default: return $urandom();
        endcase
    endfunction

    // the interval must not end before the last tick of the batch
    task automatic random_phase();
        logic [STEP_W-1:0] steps[$];
        logic [63:0]       reach;
        logic [63:0]       dur;
        t_val              from;
        int                n;
        n = $urandom_range(4, 40);
        reach = 64'(time_spent);
        for (int k = 0; k < n; k++) begin
            steps.push_back(pick_step());
            reach += 64'(steps[k]);
        end
        case ($urandom_range(0, 3))
            0:       dur = reach + 1 + 64'($urandom_range(0, 255));
            1:       dur = reach + 1 + (reach * 64'($urandom_range(1, 16))) / 4;
            2:       dur = reach + 1 + 64'($urandom());
            default: dur = 64'hFFFF_FFFF;
        endcase
        if (dur > 64'hFFFF_FFFF) dur = 64'hFFFF_FFFF;
        idle_on <= ($urandom_range(0, 3) != 0) && (ticks_sent < CALM_TICKS);
        from = random_level();
        load_interval(t_val'(dur), from, ($urandom_range(0, 9) == 0) ? from : random_level(),
                      t_mode'($urandom_range(0, 3)));
        for (int k = 0; k < n; k++) begin
            if (!hold_req && ticks_sent >= HOLD_AT && k + 2 <= n) hold_req <= 1'b1;
            send_tick(steps[k]);
        end
        settle();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_interval(t_val'(200000), LEVEL_MIN, LEVEL_MAX, MODE_LINEAR);
        send_tick('0);
        send_tick(STEP_W'(1));
        send_tick('1);
        send_tick(STEP_W'(50000));
        send_tick(STEP_W'(12345));
        settle();
        load_interval(time_spent + 300000, LEVEL_MAX, LEVEL_MIN, MODE_EASE_IN);
        send_tick(STEP_W'(30000));
        send_tick('1);
        send_tick('1);
        settle();
        load_interval(time_spent + 250000, 32'h0001_0000, 32'hFFFF_0000, MODE_EASE_OUT);
        send_tick(STEP_W'(40000));
        send_tick('1);
        send_tick(STEP_W'(100));
        settle();
        load_interval('1, '0, LEVEL_MAX, MODE_IN_OUT);
        send_tick('1);
        send_tick(STEP_W'(1));
        settle();
        load_interval(time_spent + 2, LEVEL_MIN, LEVEL_MAX, MODE_IN_OUT);
        send_tick(STEP_W'(1));
        settle();

        while (ticks_sent < TARGET_TICKS) random_phase();

        // zero duration ends the interval at once; later ticks give no result and later writes do not restart it
        idle_on <= 1'b0;
        load_interval('0, random_level(), random_level(), t_mode'($urandom_range(0, 3)));
        send_tick(STEP_W'($urandom()));
        send_tick('1);
        send_tick('0);
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        load_interval('1, random_level(), random_level(), MODE_LINEAR);
        send_tick(STEP_W'(1000));
        send_tick('1);
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- eased_interval_interpolator_core.f -----
hw/rtl/eii_pkg.sv
hw/rtl/eii_serial_div.sv
hw/rtl/eii_serial_mul.sv
hw/rtl/eased_interval_interpolator_core.sv
tb/sv/eii_interval_checker.sv
tb/sv/tb_eased_interval_interpolator_core.sv
